### sv/nc_pkg.sv
package nc_pkg;

    localparam int NEIGHBOR_ENTRIES = 16;
    localparam int IDX_W = (NEIGHBOR_ENTRIES > 1) ? $clog2(NEIGHBOR_ENTRIES) : 1;
    localparam int CNT_W = $clog2(NEIGHBOR_ENTRIES + 1);

    localparam logic [1:0] REQ_UPDATE = 2'd0;
    localparam logic [1:0] REQ_LOOKUP = 2'd1;
    localparam logic [1:0] REQ_TICK   = 2'd2;

    localparam logic [1:0]  STATE_STALE     = 2'd2;
    localparam logic [30:0] STALE_AGE_RESET = 31'd30000;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] address_high;
        logic [63:0] address_low;
        logic [47:0] mac_in;
        logic [1:0]  neighbor_state;
        logic [31:0] now;
    } nc_req_t;

    typedef struct packed {
        logic        status;
        logic [47:0] mac_out;
    } nc_rsp_t;

    typedef struct packed {
        logic [63:0] address_high;
        logic [63:0] address_low;
        logic [47:0] mac;
        logic [1:0]  state;
        logic [31:0] updated;
    } nc_entry_t;

    typedef struct packed {
        logic match;
        logic stale;
        logic older;
    } nc_eval_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } nc_state_t;

endpackage

### sv/nc_entry_eval.sv
module nc_entry_eval (
    input  nc_pkg::nc_entry_t entry,
    input  logic              active,
    input  logic [63:0]       address_high,
    input  logic [63:0]       address_low,
    input  logic [31:0]       now,
    input  logic [31:0]       oldest,
    input  logic [30:0]       stale_age,
    output nc_pkg::nc_eval_t  eval
);

    logic [31:0] age;
    logic [31:0] diff;

    assign age  = now - entry.updated;
    assign diff = entry.updated - oldest;

    always_comb
    begin
        eval.match = active && (entry.address_high == address_high) &&
                     (entry.address_low == address_low);
        // A negative age in the signed wrap sense never makes an entry stale.
        eval.stale = active && !age[31] && (age[30:0] >= stale_age);
        eval.older = diff[31];
    end

endmodule

### sv/ipv6_neighbor_cache_core.sv
// IPv6 neighbor cache with oldest-entry replacement.
// A request transaction is taken at a rising edge where start is high and busy is low;
// req carries the request type, address, MAC, state and time.  Every request gives
// exactly one result transaction: result_valid is high for one cycle with result.
// The receiver cannot stall, so results are never held back.
// Update, lookup and tick requests scan all NEIGHBOR_ENTRIES entries through the
// single read port of the entry memory, one entry per cycle, with a registered read;
// a tick writes stale entries back behind the read as it goes. The result is
// registered from the finish state, and busy stays high through the scan and the
// finish state, so the next request is taken only once the previous one is done.
// A rejected update or an unknown request type gives its result in the next cycle
// and leaves the block idle. The user must write stale_age through cfg_we/cfg_wdata
// only while the block is idle; the block does not enforce this. Reset marks every
// entry inactive through per-entry valid flip-flops, clears the current time and
// loads stale_age with 30000; no clearing pass is needed.
module ipv6_neighbor_cache_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    output logic            busy,
    input  nc_pkg::nc_req_t req,
    output logic            result_valid,
    output nc_pkg::nc_rsp_t result,
    input  logic            cfg_we,
    input  logic [30:0]     cfg_wdata
);

    localparam int N = nc_pkg::NEIGHBOR_ENTRIES;
    localparam int IW = nc_pkg::IDX_W;
    localparam int CW = nc_pkg::CNT_W;

    nc_pkg::nc_state_t state_reg, state_next;

    nc_pkg::nc_entry_t mem [N];
    nc_pkg::nc_entry_t rdata_reg;

    logic [N-1:0]   active_reg;
    logic [CW-1:0]  rd_cnt_reg;
    logic           chk_vld_reg;
    logic [IW-1:0]  chk_idx_reg;
    logic           found_reg;
    logic           free_found_reg;
    logic [IW-1:0]  found_idx_reg;
    logic [IW-1:0]  free_idx_reg;
    logic [IW-1:0]  old_idx_reg;
    logic [31:0]    oldest_reg;
    logic [47:0]    found_mac_reg;
    logic [31:0]    current_time_reg;
    logic [30:0]    stale_age_reg;
    nc_pkg::nc_req_t req_reg;
    logic           result_valid_reg;
    nc_pkg::nc_rsp_t result_reg;

    logic           accept;
    logic           req_ok;
    logic           rd_en;
    logic [IW-1:0]  rd_idx;
    logic           mem_we;
    logic [IW-1:0]  mem_waddr;
    nc_pkg::nc_entry_t mem_wdata;
    logic [IW-1:0]  target_idx;
    logic           last_chk;
    nc_pkg::nc_eval_t ev;

    nc_entry_eval u_eval (
        .entry        (rdata_reg),
        .active       (active_reg[chk_idx_reg]),
        .address_high (req_reg.address_high),
        .address_low  (req_reg.address_low),
        .now          (req_reg.now),
        .oldest       (oldest_reg),
        .stale_age    (stale_age_reg),
        .eval         (ev)
    );

    assign accept = start && !busy;
    assign rd_idx = rd_cnt_reg[IW-1:0];
    assign last_chk = chk_vld_reg && (chk_idx_reg == IW'(N - 1));
    assign target_idx = found_reg ? found_idx_reg :
                        (free_found_reg ? free_idx_reg : old_idx_reg);

    // Lookups and ticks always scan; updates scan only if MAC and address pass.
    always_comb
    begin
        case (req.req_type)
            nc_pkg::REQ_UPDATE:
                req_ok = !req.mac_in[40] && (req.mac_in != 48'd0) &&
                         !((req.address_high == 64'd0) && (req.address_low == 64'd0)) &&
                         (req.address_high[63:56] != 8'hFF);
            nc_pkg::REQ_LOOKUP: req_ok = 1'b1;
            nc_pkg::REQ_TICK:   req_ok = 1'b1;
            default:            req_ok = 1'b0;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            nc_pkg::ST_IDLE:
                if (accept && req_ok)
                    state_next = nc_pkg::ST_SCAN;
            nc_pkg::ST_SCAN:
                if (last_chk)
                    state_next = nc_pkg::ST_FINISH;
            nc_pkg::ST_FINISH:
                state_next = nc_pkg::ST_IDLE;
            default:
                state_next = nc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        busy      = 1'b0;
        rd_en     = 1'b0;
        mem_we    = 1'b0;
        mem_waddr = chk_idx_reg;
        mem_wdata = rdata_reg;
        case (state_reg)
            nc_pkg::ST_IDLE:
            begin
                busy = 1'b0;
            end
            nc_pkg::ST_SCAN:
            begin
                busy  = 1'b1;
                rd_en = (rd_cnt_reg < CW'(N));
                // The write-back trails the read, so it never meets the entry being read.
                mem_we = chk_vld_reg && (req_reg.req_type == nc_pkg::REQ_TICK) && ev.stale;
                mem_wdata.state = nc_pkg::STATE_STALE;
            end
            nc_pkg::ST_FINISH:
            begin
                busy      = 1'b1;
                mem_we    = (req_reg.req_type == nc_pkg::REQ_UPDATE);
                mem_waddr = target_idx;
                mem_wdata.address_high = req_reg.address_high;
                mem_wdata.address_low  = req_reg.address_low;
                mem_wdata.mac          = req_reg.mac_in;
                mem_wdata.state        = req_reg.neighbor_state;
                mem_wdata.updated      = current_time_reg;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
            rdata_reg <= mem[rd_idx];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= nc_pkg::ST_IDLE;
            active_reg       <= '0;
            rd_cnt_reg       <= '0;
            chk_vld_reg      <= 1'b0;
            found_reg        <= 1'b0;
            free_found_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
            current_time_reg <= 32'd0;
            stale_age_reg    <= nc_pkg::STALE_AGE_RESET;
        end
        else
        begin
            state_reg        <= state_next;
            chk_vld_reg      <= rd_en;
            result_valid_reg <= (accept && !req_ok) || (state_reg == nc_pkg::ST_FINISH);
            if (cfg_we)
                stale_age_reg <= cfg_wdata;
            if (rd_en)
                rd_cnt_reg <= rd_cnt_reg + CW'(1);
            if (accept)
            begin
                rd_cnt_reg     <= '0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
                if (req.req_type == nc_pkg::REQ_TICK)
                    current_time_reg <= req.now;
            end
            if (chk_vld_reg)
            begin
                if (ev.match)
                    found_reg <= 1'b1;
                if (!active_reg[chk_idx_reg])
                    free_found_reg <= 1'b1;
            end
            if ((state_reg == nc_pkg::ST_FINISH) && mem_we)
                active_reg[target_idx] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg           <= req;
            result_reg.status <= 1'b1;
            result_reg.mac_out <= 48'd0;
        end
        if (rd_en)
            chk_idx_reg <= rd_idx;
        if (chk_vld_reg)
        begin
            if (ev.match && !found_reg)
            begin
                found_idx_reg <= chk_idx_reg;
                found_mac_reg <= rdata_reg.mac;
            end
            if (!active_reg[chk_idx_reg] && !free_found_reg)
                free_idx_reg <= chk_idx_reg;
            // Oldest search in signed wrap order, starting from entry zero.
            if ((chk_idx_reg == IW'(0)) || ev.older)
            begin
                old_idx_reg <= chk_idx_reg;
                oldest_reg  <= rdata_reg.updated;
            end
        end
        if (state_reg == nc_pkg::ST_FINISH)
        begin
            if (req_reg.req_type == nc_pkg::REQ_LOOKUP)
            begin
                result_reg.status  <= !found_reg;
                result_reg.mac_out <= found_reg ? found_mac_reg : 48'd0;
            end
            else
            begin
                result_reg.status  <= 1'b0;
                result_reg.mac_out <= 48'd0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result strobe while a request is in progress");

    a_finish_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == nc_pkg::ST_FINISH) |=> result_valid)
        else $error("finished request produced no result");

    a_tick_time: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req.req_type == nc_pkg::REQ_TICK)) |=> (current_time_reg == $past(req.now)))
        else $error("tick did not load the current time");

    a_scan_write: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == nc_pkg::ST_SCAN) && mem_we) |-> (req_reg.req_type == nc_pkg::REQ_TICK))
        else $error("entry written during a scan other than a tick");

endmodule

### test/ipv6_neighbor_cache_core_test.sv
module ipv6_neighbor_cache_core_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] REQ_UNKNOWN = 2'd3;
    localparam int SETTLE_CYCLES = nc_pkg::NEIGHBOR_ENTRIES + 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int POOL_SIZE = 32;
    localparam int PHASE_ITEMS = 190;
    localparam int PHASES = 6;

    localparam logic [63:0] HOST_HIGH = 64'h2001_0db8_0000_0001;
    localparam logic [63:0] HOST_LOW  = 64'h0000_0000_0000_0001;
    localparam logic [63:0] ALL_ONES  = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [47:0] MAC_TOP   = 48'hFE_FF_FF_FF_FF_FF;
    localparam logic [47:0] MAC_GROUP = 48'h01_00_5E_00_00_01;

    typedef enum logic [1:0] {
        OP_REQUEST,
        OP_SET_STALE_AGE,
        OP_DRAIN
    } op_kind_t;

    typedef struct packed {
        op_kind_t        kind;
        nc_pkg::nc_req_t rq;
        logic [30:0]     value;
    } pending_op_t;

    logic            clk = 1'b0;
    logic            rst_n = 1'b0;
    logic            start = 1'b0;
    logic            busy;
    nc_pkg::nc_req_t req = '0;
    logic            result_valid;
    nc_pkg::nc_rsp_t result;
    logic            cfg_we = 1'b0;
    logic [30:0]     cfg_wdata = '0;

    ipv6_neighbor_cache_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .req          (req),
        .result_valid (result_valid),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata)
    );

    always #2 clk = ~clk;

    // Predicted neighbor table.
    logic [63:0] cache_addr_high [nc_pkg::NEIGHBOR_ENTRIES];
    logic [63:0] cache_addr_low  [nc_pkg::NEIGHBOR_ENTRIES];
    logic [47:0] cache_mac       [nc_pkg::NEIGHBOR_ENTRIES];
    logic [1:0]  cache_state     [nc_pkg::NEIGHBOR_ENTRIES];
    logic [31:0] cache_stamp     [nc_pkg::NEIGHBOR_ENTRIES];
    logic        cache_live      [nc_pkg::NEIGHBOR_ENTRIES];
    logic [31:0] cache_clock;
    logic [30:0] stale_limit;

    pending_op_t     op_queue[$];
    nc_pkg::nc_rsp_t expected_results[$];
    logic [63:0]     pool_high [POOL_SIZE];
    logic [63:0]     pool_low  [POOL_SIZE];
    logic [31:0]     tick_clock = '0;

    logic taken = 1'b0;
    int   burst_left = 1;
    int   gap_left = 0;
    int   idle_cycles = 0;
    int   quiet_cycles = 0;
    int   mismatch_count = 0;

    function automatic int find_neighbor(logic [63:0] hi, logic [63:0] lo);
        int hit;
        hit = -1;
        for (int i = nc_pkg::NEIGHBOR_ENTRIES - 1; i >= 0; i--)
            if (cache_live[i] && cache_addr_high[i] == hi && cache_addr_low[i] == lo)
                hit = i;
        return hit;
    endfunction

    function automatic int pick_victim(logic [63:0] hi, logic [63:0] lo);
        int          slot;
        logic [31:0] oldest;
        logic [31:0] diff;
        slot = find_neighbor(hi, lo);
        if (slot >= 0)
            return slot;
        for (int i = 0; i < nc_pkg::NEIGHBOR_ENTRIES; i++)
            if (!cache_live[i])
                return i;
        // Table full: the oldest stamp wins, compared across the 32-bit wrap.
        slot = 0;
        oldest = cache_stamp[0];
        for (int i = 1; i < nc_pkg::NEIGHBOR_ENTRIES; i++)
        begin
            diff = cache_stamp[i] - oldest;
            if (diff[31])
            begin
                slot = i;
                oldest = cache_stamp[i];
            end
        end
        return slot;
    endfunction

    function automatic nc_pkg::nc_rsp_t serve_request(nc_pkg::nc_req_t rq);
        nc_pkg::nc_rsp_t rsp;
        int              slot;
        logic [31:0]     age;
        rsp.status = 1'b1;
        rsp.mac_out = '0;
        case (rq.req_type)
            nc_pkg::REQ_UPDATE:
            begin
                if (!rq.mac_in[40] && rq.mac_in != '0 &&
                    {rq.address_high, rq.address_low} != '0 &&
                    rq.address_high[63:56] != 8'hFF)
                begin
                    slot = pick_victim(rq.address_high, rq.address_low);
                    cache_addr_high[slot] = rq.address_high;
                    cache_addr_low[slot] = rq.address_low;
                    cache_mac[slot] = rq.mac_in;
                    cache_state[slot] = rq.neighbor_state;
                    cache_stamp[slot] = cache_clock;
                    cache_live[slot] = 1'b1;
                    rsp.status = 1'b0;
                end
            end
            nc_pkg::REQ_LOOKUP:
            begin
                slot = find_neighbor(rq.address_high, rq.address_low);
                if (slot >= 0)
                begin
                    rsp.status = 1'b0;
                    rsp.mac_out = cache_mac[slot];
                end
            end
            nc_pkg::REQ_TICK:
            begin
                cache_clock = rq.now;
                for (int i = 0; i < nc_pkg::NEIGHBOR_ENTRIES; i++)
                begin
                    age = rq.now - cache_stamp[i];
                    if (cache_live[i] && !age[31] && age >= {1'b0, stale_limit})
                        cache_state[i] = nc_pkg::STATE_STALE;
                end
                rsp.status = 1'b0;
            end
            default:
            begin
            end
        endcase
        return rsp;
    endfunction

    function automatic nc_pkg::nc_req_t make_req(logic [1:0] kind, logic [63:0] hi,
                                                 logic [63:0] lo, logic [47:0] mac,
                                                 logic [1:0] nst, logic [31:0] t);
        nc_pkg::nc_req_t rq;
        rq.req_type = kind;
        rq.address_high = hi;
        rq.address_low = lo;
        rq.mac_in = mac;
        rq.neighbor_state = nst;
        rq.now = t;
        return rq;
    endfunction

    function automatic void queue_op(op_kind_t kind, nc_pkg::nc_req_t rq, logic [30:0] value);
        pending_op_t op;
        op.kind = kind;
        op.rq = rq;
        op.value = value;
        op_queue.push_back(op);
    endfunction

    // Mostly addresses from a small pool so that refreshes, hits and replacements
    // happen; the rest are invalid or fully random addresses and MACs.
    function automatic nc_pkg::nc_req_t random_request(int span);
        nc_pkg::nc_req_t rq;
        int              pick;
        int              roll;
        rq.address_high = {$urandom, $urandom};
        rq.address_low = {$urandom, $urandom};
        rq.mac_in = {16'($urandom), $urandom};
        rq.neighbor_state = 2'($urandom);
        rq.now = $urandom;
        roll = $urandom_range(0, 99);
        if (roll < 47)
            rq.req_type = nc_pkg::REQ_UPDATE;
        else if (roll < 82)
            rq.req_type = nc_pkg::REQ_LOOKUP;
        else if (roll < 97)
            rq.req_type = nc_pkg::REQ_TICK;
        else
            rq.req_type = REQ_UNKNOWN;
        roll = $urandom_range(0, 99);
        if (roll < 88)
        begin
            pick = $urandom_range(0, span - 1);
            rq.address_high = pool_high[pick];
            rq.address_low = pool_low[pick];
        end
        else if (roll < 91)
        begin
            rq.address_high = '0;
            rq.address_low = '0;
        end
        else if (roll < 94)
            rq.address_high[63:56] = 8'hFF;
        roll = $urandom_range(0, 99);
        if (roll < 90)
            rq.mac_in[40] = 1'b0;
        else if (roll < 93)
            rq.mac_in = '0;
        if (rq.req_type == nc_pkg::REQ_TICK)
        begin
            roll = $urandom_range(0, 99);
            if (roll < 80)
                tick_clock += $urandom_range(0, 40000);
            else if (roll < 88)
                tick_clock -= $urandom_range(0, 1000);
            else if (roll < 94)
                tick_clock = ALL_ONES[31:0] - $urandom_range(0, 50000);
            else
                tick_clock = $urandom;
            rq.now = tick_clock;
        end
        return rq;
    endfunction

    function automatic void note_mismatch(string what, logic [47:0] want, logic [47:0] got);
        mismatch_count++;
        $display("%0t ns: %s mismatch: expected 0x%0h, actual 0x%0h",
                 $time, what, want, got);
    endfunction

    // Request driver: one item at a time, in bursts separated by random gaps.
    always @(negedge clk)
    begin : drive
        pending_op_t     op;
        logic            drive_start;
        logic            drive_we;
        nc_pkg::nc_req_t drive_req;
        logic [30:0]     drive_wdata;
        drive_start = start;
        drive_we = 1'b0;
        drive_req = req;
        drive_wdata = cfg_wdata;
        if (rst_n)
        begin
            if (start && taken)
                drive_start = 1'b0;
            if (expected_results.size() == 0 && !drive_start)
                idle_cycles++;
            else
                idle_cycles = 0;
            if (!drive_start)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (op_queue.size() > 0)
                begin
                    case (op_queue[0].kind)
                        OP_REQUEST:
                        begin
                            op = op_queue.pop_front();
                            drive_start = 1'b1;
                            drive_req = op.rq;
                            burst_left--;
                            if (burst_left <= 0)
                            begin
                                burst_left = $urandom_range(1, 12);
                                gap_left = ($urandom_range(0, 2) == 0) ? 0 :
                                           $urandom_range(1, 25);
                            end
                        end
                        OP_DRAIN:
                        begin
                            if (expected_results.size() == 0)
                                void'(op_queue.pop_front());
                        end
                        OP_SET_STALE_AGE:
                        begin
                            // The register is only written once the block has gone quiet.
                            if (idle_cycles >= SETTLE_CYCLES)
                            begin
                                op = op_queue.pop_front();
                                drive_we = 1'b1;
                                drive_wdata = op.value;
                                idle_cycles = 0;
                            end
                        end
                        default:
                        begin
                            void'(op_queue.pop_front());
                        end
                    endcase
                end
            end
        end
        start <= drive_start;
        req <= drive_req;
        cfg_we <= drive_we;
        cfg_wdata <= drive_wdata;
    end

    // Monitor: predicts on every accepted request and checks every result.
    always @(posedge clk)
    begin : observe
        nc_pkg::nc_rsp_t want;
        if (rst_n)
        begin
            taken <= start && !busy;
            if (cfg_we)
                stale_limit = cfg_wdata;
            if (result_valid)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatch_count++;
                    $display("%0t ns: unexpected result transaction: status %0b, mac_out 0x%0h",
                             $time, result.status, result.mac_out);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (result.status !== want.status)
                        note_mismatch("status", 48'(want.status), 48'(result.status));
                    if (result.mac_out !== want.mac_out)
                        note_mismatch("mac_out", want.mac_out, result.mac_out);
                end
            end
            if (start && !busy)
                expected_results.push_back(serve_request(req));
            if (result_valid || (start && !busy) || cfg_we)
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t ns: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("** ipv6_neighbor_cache_core: FAILED **");
                $finish;
            end
        end
    end

    initial
    begin
        logic [30:0] setting;
        int          span;
        for (int i = 0; i < nc_pkg::NEIGHBOR_ENTRIES; i++)
        begin
            cache_state[i] = '0;
            cache_stamp[i] = '0;
            cache_live[i] = 1'b0;
        end
        cache_clock = '0;
        stale_limit = nc_pkg::STALE_AGE_RESET;

        // Odd pool entries share the upper half with their neighbor, so a lookup
        // must compare both halves.
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_high[i] = (i % 2 == 1) ? pool_high[i - 1] : {$urandom, $urandom};
            pool_low[i] = {$urandom, $urandom};
            if (pool_high[i][63:56] == 8'hFF)
                pool_high[i][56] = 1'b0;
        end

        // Directed part: rejections, refresh, odd states, extreme values and times.
        queue_op(OP_REQUEST, make_req(nc_pkg::REQ_LOOKUP, HOST_HIGH, HOST_LOW, '0, 2'd1, '0),
                 '0);
        queue_op(OP_REQUEST, make_req(nc_pkg::REQ_UPDATE, '0, '0, MAC_TOP, 2'd1, '0), '0);
        queue_op(OP_REQUEST, make_req(nc_pkg::REQ_UPDATE, 64'hFF02_0000_0000_0000, 64'd1,
                                      MAC_TOP, 2'd1, '0), '0);
        queue_op(OP_REQUEST, make_req(nc_pkg::REQ_UPDATE, HOST_HIGH, HOST_LOW, '0, 2'd1, '0),
                 '0);
        queue_op(OP_REQUEST, make_req(nc_pkg::REQ_UPDATE, HOST_HIGH, HOST_LOW, MAC_GROUP,
                                      2'd1, '0), '0);
        queue_op(OP_REQUEST, make_req(nc_pkg::REQ_UPDATE, HOST_HIGH, HOST_LOW,
                                      48'hFFFF_FFFF_FFFF, 2'd1, '0), '0);
        queue_op(OP_REQUEST, make_req(nc_pkg::REQ_UPDATE, HOST_HIGH, HOST_LOW, MAC_TOP,
                                      2'd1, '0), '0);
        queue_op(OP_REQUEST, make_req(nc_pkg::REQ_LOOKUP, HOST_HIGH, HOST_LOW, '0, 2'd1, '0),
                 '0);
        queue_op(OP_REQUEST, make_req(nc_pkg::REQ_UPDATE, HOST_HIGH, HOST_LOW, 48'd1,
                                      2'd2, '0), '0);
        queue_op(OP_REQUEST, make_req(nc_pkg::REQ_LOOKUP, HOST_HIGH, HOST_LOW, '0, 2'd1, '0),
                 '0);
        queue_op(OP_REQUEST, make_req(nc_pkg::REQ_UPDATE, 64'hFEFF_FFFF_FFFF_FFFF, ALL_ONES,
                                      48'h02_00_00_00_00_00, 2'd0, '0), '0);
        queue_op(OP_REQUEST, make_req(nc_pkg::REQ_UPDATE, '0, 64'd1, 48'h00_12_34_56_78_9A,
                                      2'd3, '0), '0);
        queue_op(OP_REQUEST, make_req(nc_pkg::REQ_LOOKUP, 64'hFEFF_FFFF_FFFF_FFFF, ALL_ONES,
                                      '0, 2'd1, '0), '0);
        queue_op(OP_REQUEST, make_req(nc_pkg::REQ_LOOKUP, '0, 64'd1, '0, 2'd1, '0), '0);
        queue_op(OP_REQUEST, make_req(nc_pkg::REQ_LOOKUP, ALL_ONES, ALL_ONES, '0, 2'd1, '0),
                 '0);
        queue_op(OP_REQUEST, make_req(nc_pkg::REQ_LOOKUP, HOST_HIGH, HOST_LOW ^ 64'd1, '0,
                                      2'd1, '0), '0);
        queue_op(OP_REQUEST, make_req(REQ_UNKNOWN, HOST_HIGH, HOST_LOW, MAC_TOP, 2'd1,
                                      32'hFFFF_FFFF), '0);
        queue_op(OP_REQUEST, make_req(nc_pkg::REQ_TICK, '0, '0, '0, 2'd0, 32'hFFFF_FFFF), '0);
        queue_op(OP_REQUEST, make_req(nc_pkg::REQ_TICK, '0, '0, '0, 2'd0, 32'd0), '0);
        queue_op(OP_REQUEST, make_req(nc_pkg::REQ_TICK, '0, '0, '0, 2'd0, 32'd30000), '0);
        queue_op(OP_REQUEST, make_req(nc_pkg::REQ_UPDATE, HOST_HIGH ^ 64'd1, HOST_LOW,
                                      MAC_TOP, 2'd2, '0), '0);
        queue_op(OP_REQUEST, make_req(nc_pkg::REQ_LOOKUP, HOST_HIGH ^ 64'd1, HOST_LOW, '0,
                                      2'd1, '0), '0);

        // Random phases, each under its own stale age; the first keeps the reset value.
        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                1: setting = 31'd1;
                2: setting = 31'h7FFF_FFFF;
                3: setting = 31'd0;
                4: setting = 31'd100;
                default: setting = 31'($urandom_range(1, 200000));
            endcase
            if (p > 0)
                queue_op(OP_SET_STALE_AGE, '0, setting);
            span = (p % 3 == 0) ? POOL_SIZE : ((p % 3 == 1) ? 10 : 20);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (n == PHASE_ITEMS / 2 && p % 2 == 1)
                    queue_op(OP_DRAIN, '0, '0);
                queue_op(OP_REQUEST, random_request(span), '0);
            end
        end

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        do @(posedge clk); while (op_queue.size() != 0 || start);
        do @(negedge clk); while (expected_results.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (expected_results.size() != 0)
        begin
            mismatch_count += expected_results.size();
            $display("%0t ns: %0d expected results never arrived", $time, expected_results.size());
        end
        if (mismatch_count == 0)
            $display("** ipv6_neighbor_cache_core: PASSED **");
        else
            $display("** ipv6_neighbor_cache_core: FAILED **");
        $finish;
    end

endmodule

### files.f
sv/nc_pkg.sv
sv/nc_entry_eval.sv
sv/ipv6_neighbor_cache_core.sv
test/ipv6_neighbor_cache_core_test.sv
